[rtl/core/aip_pkg.sv]
package aip_pkg;

    // fixed field widths of the channels
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned BASE_W      = 6;
    localparam int unsigned DIGIT_W     = 6;
    localparam int unsigned VALUE_OUT_W = 32;
    localparam int unsigned COUNT_OUT_W = 16;
    localparam int unsigned EXT_W       = 64;

    // queue between front and back, power of two depth
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // radix codes
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

    // classified character as it travels through the queue
    typedef struct packed {
        logic               is_space;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               is_alnum;
        logic [DIGIT_W-1:0] digit;
    } t_char_class;

    function automatic t_char_class classify(input logic [CHAR_W-1:0] c);
        t_char_class k;
        k.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        k.is_minus = (c == CH_MINUS);
        k.is_zero  = (c == CH_ZERO);
        k.is_x     = (c == CH_LX) || (c == CH_UX);
        k.is_alnum = 1'b1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            k.digit = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            k.digit = DIGIT_W'(c - CH_LA + LETTER_OFS);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            k.digit = DIGIT_W'(c - CH_UA + LETTER_OFS);
        end else begin
            k.is_alnum = 1'b0;
            k.digit    = '0;
        end
        return k;
    endfunction

endpackage

[rtl/core/aip_front.sv]
module aip_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [aip_pkg::CHAR_W-1:0]    i_char_code,
    output logic                          o_in_stall,
    output logic                          o_push_valid,
    output aip_pkg::t_char_class          o_push_class,
    input  logic                          i_push_full
);

    logic                 r_valid;
    logic                 n_valid;
    aip_pkg::t_char_class r_class;
    logic                 take;

    // input stage holds while the queue is full
    assign o_in_stall   = r_valid && i_push_full;
    assign take         = i_in_valid && !o_in_stall;
    assign o_push_valid = r_valid;
    assign o_push_class = r_class;

    // stage occupancy
    always_comb begin
        if (take) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_push_full) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // classify on transfer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_class <= aip_pkg::classify(i_char_code);
        end
    end

endmodule

[rtl/core/aip_queue.sv]
module aip_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    input  aip_pkg::t_char_class  i_push_class,
    output logic                  o_full,
    output logic                  o_head_valid,
    output aip_pkg::t_char_class  o_head_class,
    input  logic                  i_pop
);

    aip_pkg::t_char_class             r_mem [aip_pkg::QUEUE_DEPTH];
    logic [aip_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [aip_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [aip_pkg::QCNT_W-1:0]       r_count;
    logic                             push;
    logic                             pop;

    assign o_full       = (r_count == aip_pkg::QCNT_W'(aip_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_class = r_mem[r_rd_ptr];
    assign push         = i_push_valid && !o_full;
    assign pop          = i_pop && o_head_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_class;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= aip_pkg::QCNT_W'(aip_pkg::QUEUE_DEPTH))
        else $error("queue fill level beyond depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill level missed a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while empty");
`endif

endmodule

[rtl/core/aip_back.sv]
module aip_back #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [aip_pkg::BASE_W-1:0]         i_number_base,
    input  logic                               i_head_valid,
    input  aip_pkg::t_char_class               i_head_class,
    output logic                               o_pop,
    output logic                               o_out_valid,
    output logic [aip_pkg::VALUE_OUT_W-1:0]    o_parsed_value,
    output logic                               o_overflowed,
    output logic [aip_pkg::COUNT_OUT_W-1:0]    o_chars_used,
    input  logic                               i_out_stall
);

    localparam int unsigned MAC_W = VALUE_BITS + aip_pkg::BASE_W;

    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_ZERO   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_START  = 2'd3;

    logic [1:0]                   r_phase,  n_phase;
    logic [aip_pkg::BASE_W-1:0]   r_base,   n_base;
    logic [VALUE_BITS-1:0]        r_acc,    n_acc;
    logic                         r_minus,  n_minus;
    logic                         r_ovf,    n_ovf;
    logic [COUNT_BITS-1:0]        r_count,  n_count;

    logic [COUNT_BITS-1:0]        count_inc;
    logic [aip_pkg::BASE_W-1:0]   eff_base;
    logic                         dig_path;
    logic                         digit_ok;
    logic                         emit;
    logic [MAC_W-1:0]             mac;
    logic                         mac_over;
    logic [VALUE_BITS-1:0]        res_val;
    logic [aip_pkg::EXT_W-1:0]    res_ext;
    logic [31:0]                  cnt_ext;

    logic                         r_out_valid;
    logic [aip_pkg::VALUE_OUT_W-1:0] r_out_value;
    logic                         r_out_ovf;
    logic [aip_pkg::COUNT_OUT_W-1:0] r_out_count;

    aip_pkg::t_char_class         h;

    assign h = i_head_class;

    // saturating character count
    assign count_inc = (&r_count) ? r_count : r_count + 1'b1;

    // multiply-add by the radix, overflow from the upper product bits
    assign mac      = MAC_W'(r_acc) * MAC_W'(eff_base) + MAC_W'(h.digit);
    assign mac_over = |mac[MAC_W-1:VALUE_BITS];
    assign digit_ok = h.is_alnum && (h.digit < eff_base);

    // parse sequencer
    always_comb begin
        n_phase  = r_phase;
        n_base   = r_base;
        n_acc    = r_acc;
        n_minus  = r_minus;
        n_ovf    = r_ovf;
        n_count  = r_count;
        eff_base = r_base;
        dig_path = 1'b0;
        emit     = 1'b0;
        unique case (r_phase)
            PH_SPACE, PH_START: begin
                priority if (r_phase == PH_SPACE && h.is_space) begin
                    n_count = count_inc;
                end else if (r_phase == PH_SPACE && h.is_minus) begin
                    n_minus = 1'b1;
                    n_count = count_inc;
                    n_phase = PH_START;
                end else if ((i_number_base == aip_pkg::BASE_HEX ||
                              i_number_base == aip_pkg::BASE_AUTO) && h.is_zero) begin
                    n_count = count_inc;
                    n_phase = PH_ZERO;
                end else begin
                    eff_base = (i_number_base == aip_pkg::BASE_AUTO) ?
                               aip_pkg::BASE_DEC : i_number_base;
                    dig_path = 1'b1;
                end
            end
            PH_ZERO: begin
                if (h.is_x) begin
                    n_base  = aip_pkg::BASE_HEX;
                    n_count = count_inc;
                    n_phase = PH_DIGITS;
                end else begin
                    eff_base = (i_number_base == aip_pkg::BASE_AUTO) ?
                               aip_pkg::BASE_OCT : i_number_base;
                    dig_path = 1'b1;
                end
            end
            PH_DIGITS: begin
                dig_path = 1'b1;
            end
        endcase
        // digit accumulate or terminate
        if (dig_path) begin
            if (digit_ok) begin
                n_base  = eff_base;
                n_ovf   = r_ovf || mac_over;
                n_acc   = (r_ovf || mac_over) ? r_acc : mac[VALUE_BITS-1:0];
                n_phase = PH_DIGITS;
                n_count = count_inc;
            end else begin
                emit    = 1'b1;
                n_phase = PH_SPACE;
                n_base  = '0;
                n_acc   = '0;
                n_minus = 1'b0;
                n_ovf   = 1'b0;
                n_count = '0;
            end
        end
    end

    // take the head unless a result has nowhere to go
    assign o_pop = i_head_valid && (!emit || !r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_base  <= '0;
            r_acc   <= '0;
            r_minus <= 1'b0;
            r_ovf   <= 1'b0;
            r_count <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_ovf   <= n_ovf;
            r_count <= n_count;
        end
    end

    // final value: saturate, else apply sign
    assign res_val = r_ovf ? '1 : (r_minus ? (~r_acc + 1'b1) : r_acc);
    assign res_ext = aip_pkg::EXT_W'(res_val);
    assign cnt_ext = 32'(r_count);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_value <= res_ext[aip_pkg::VALUE_OUT_W-1:0];
            r_out_ovf   <= r_ovf;
            r_out_count <= cnt_ext[aip_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_out_value;
    assign o_overflowed   = r_out_ovf;
    assign o_chars_used   = r_out_count;

`ifndef SYNTHESIS
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit) |=> (r_phase == PH_SPACE && r_count == '0 && !r_ovf))
        else $error("number state not cleared after result");
    a_acc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc != '0) |-> (r_phase == PH_DIGITS))
        else $error("accumulator nonzero outside digit phase");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(o_pop && emit))
        else $error("result issued over a stalled result");
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit && r_ovf) |=> (r_out_ovf && r_out_count == $past(cnt_ext[15:0])))
        else $error("overflow result not captured");
`endif

endmodule

[rtl/core/ascii_integer_parser_unit.sv]
// channel  | direction | handshake                     | payload
// in       | input     | i_in_valid / o_in_stall       | i_char_code
// out      | output    | o_out_valid / i_out_stall     | o_parsed_value, o_overflowed,
//          |           |                               | o_chars_used
// cfg      | input     | i_cfg_valid / o_cfg_ready     | i_cfg_data (number base)
//
// one character per cycle sustained while the input is not stalled; a character passes an
// input stage and a two-entry queue before the parse sequencer, and a result is loaded
// into the output register when the sequencer takes its terminator
// the sequencer does one multiply-add by the radix and one compare per cycle it pops
// reset is synchronous, active low, and clears the parse state and the queue
// the input stalls only when the queue is full; the queue fills only while a result
// waits under a stalled output
module ascii_integer_parser_unit #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic [aip_pkg::CHAR_W-1:0]         i_char_code,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output logic [aip_pkg::VALUE_OUT_W-1:0]    o_parsed_value,
    output logic                               o_overflowed,
    output logic [aip_pkg::COUNT_OUT_W-1:0]    o_chars_used,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_valid,
    input  logic [aip_pkg::BASE_W-1:0]         i_cfg_data,
    output logic                               o_cfg_ready
);

    logic [aip_pkg::BASE_W-1:0] r_number_base;
    logic                       push_valid;
    aip_pkg::t_char_class       push_class;
    logic                       push_full;
    logic                       head_valid;
    aip_pkg::t_char_class       head_class;
    logic                       pop;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= aip_pkg::BASE_AUTO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_number_base <= i_cfg_data;
        end
    end

    // accept and classify
    aip_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_char_code  (i_char_code),
        .o_in_stall   (o_in_stall),
        .o_push_valid (push_valid),
        .o_push_class (push_class),
        .i_push_full  (push_full)
    );

    // decoupling queue
    aip_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_class (push_class),
        .o_full       (push_full),
        .o_head_valid (head_valid),
        .o_head_class (head_class),
        .i_pop        (pop)
    );

    // parse sequencer and result register
    aip_back #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_number_base  (r_number_base),
        .i_head_valid   (head_valid),
        .i_head_class   (head_class),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_parsed_value (o_parsed_value),
        .o_overflowed   (o_overflowed),
        .o_chars_used   (o_chars_used),
        .i_out_stall    (i_out_stall)
    );

endmodule
